>>> rtl/mp2ea_pkg.sv
package mp2ea_pkg;

  // Input item kinds carried on s_tuser.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TERM = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 1;
  localparam int unsigned CFG_DATA_WIDTH  = 8;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OCCUPIED_COUNT = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VIRTUAL_COUNT  = 1'd1;

  // Fixed field widths.
  localparam int unsigned INDEX_WIDTH  = 8;
  localparam int unsigned ENERGY_WIDTH = 32;
  localparam int unsigned DEN_WIDTH    = 34;
  localparam int unsigned SUM_WIDTH    = 48;
  localparam int unsigned PROD_WIDTH   = 64;
  localparam int unsigned FRAC_BITS    = 24;
  localparam int unsigned NUM_WIDTH    = ENERGY_WIDTH + FRAC_BITS;
  localparam int unsigned TERM_WIDTH   = PROD_WIDTH - FRAC_BITS;
  localparam int unsigned S_TDATA_WIDTH = 136;
  localparam int unsigned M_TDATA_WIDTH = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_SETUP,
    ST_DIV,
    ST_FIX,
    ST_SUM
  } state_t;

endpackage

>>> rtl/mp2_energy_accumulator_core.sv
// MP2 energy accumulator. Load items (s_tuser = 0) write one orbital energy into an
// on-chip table and leave the block idle. Integral items (s_tuser = 1) read the four
// energies e_i, e_j, e_(occ+a), e_(occ+b) from the energy table one per cycle,
// form the denominator, and divide the spin-adapted integral by it with a bit-serial
// restoring divider that yields one amplitude bit per cycle. The plain integral is
// multiplied by the amplitude in the same loop, MSB first, so no hardware multiplier
// is present. An integral item occupies the block through a divide loop of AMP_BITS - 1
// steps; items whose indexes are out of range, whose denominator is zero, or whose
// amplitude saturates finish early. The result sits in an output register, so a new
// item is taken while it waits for the sink.
// The energy sum is cleared after the result of a transfer with s_tlast high.
// Table entries never loaded read as arbitrary values.
module mp2_energy_accumulator_core
  import mp2ea_pkg::*;
#(
  parameter int unsigned MAX_ORBITALS = 256,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write port.
  input  logic                       cfg_wen,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  // Input stream.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata, lowest bit up: orbital_index[7:0], orbital_energy[39:8],
  // occ_first[47:40], occ_second[55:48], virt_first[63:56], virt_second[71:64],
  // adapted_integral[103:72], plain_integral[135:104].
  input  logic [S_TDATA_WIDTH-1:0]   s_tdata,
  input  logic                       s_tuser,   // command
  input  logic                       s_tlast,   // last_term
  // Output stream.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata, lowest bit up: amplitude[31:0], energy_sum[79:32].
  output logic [M_TDATA_WIDTH-1:0]   m_tdata,
  output logic [1:0]                 m_tuser,   // zero_denominator[0], range_error[1]
  output logic                       m_tlast    // sum_done
);

  localparam int unsigned AMP_BITS   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned QBITS      = AMP_BITS - 1;
  localparam int unsigned CNT_WIDTH  = $clog2(QBITS + 1);
  localparam int unsigned ADDR_WIDTH = $clog2(MAX_ORBITALS);
  localparam logic [INDEX_WIDTH:0] MAX_INDEX = (INDEX_WIDTH + 1)'(MAX_ORBITALS);
  localparam logic [ENERGY_WIDTH-1:0] AMP_POS_LIMIT =
    ENERGY_WIDTH'((64'd1 << QBITS) - 64'd1);

  // Configuration registers.
  logic [INDEX_WIDTH-1:0] occupied_count;
  logic [INDEX_WIDTH-1:0] virtual_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_count <= INDEX_WIDTH'(1);
      virtual_count  <= INDEX_WIDTH'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_OCCUPIED_COUNT: occupied_count <= cfg_data;
        REG_VIRTUAL_COUNT:  virtual_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input field views.
  logic [INDEX_WIDTH-1:0]         in_orbital_index;
  logic [ENERGY_WIDTH-1:0]        in_orbital_energy;
  assign in_orbital_index  = s_tdata[7:0];
  assign in_orbital_energy = s_tdata[39:8];

  state_t state, state_next;

  logic s_accept;
  assign s_accept = s_tvalid && s_tready;

  // Captured integral item.
  logic [INDEX_WIDTH-1:0]  occ_i, occ_j, virt_a, virt_b;
  logic signed [ENERGY_WIDTH-1:0] adapted, plain;
  logic last_term;

  // Energy table: one write port for loads, one registered read port.
  logic [ENERGY_WIDTH-1:0] energy_table [MAX_ORBITALS];
  logic [ADDR_WIDTH-1:0]   rd_addr;
  logic [ENERGY_WIDTH-1:0] rd_data;
  logic                    tbl_wen;

  assign tbl_wen = s_accept && (s_tuser == CMD_LOAD) &&
                   ({1'b0, in_orbital_index} < MAX_INDEX);

  always_ff @(posedge clk) begin
    if (tbl_wen) begin
      energy_table[in_orbital_index[ADDR_WIDTH-1:0]] <= in_orbital_energy;
    end
    rd_data <= energy_table[rd_addr];
  end

  // Datapath registers.
  logic [2:0]                  rd_cnt;
  logic signed [DEN_WIDTH-1:0] den;
  logic                        range_err, zero_den, amp_neg, amp_sat;
  logic [DEN_WIDTH-1:0]        dm;
  logic [DEN_WIDTH-1:0]        rem;
  logic [QBITS-1:0]            num_bits;
  logic [QBITS-1:0]            quot;
  logic [CNT_WIDTH-1:0]        div_cnt;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [ENERGY_WIDTH-1:0] amp;
  logic signed [SUM_WIDTH-1:0]  energy_acc;

  // Range check on the captured indexes.
  logic [INDEX_WIDTH:0] tab_a, tab_b;
  logic                 range_bad;
  assign tab_a = {1'b0, occupied_count} + {1'b0, virt_a};
  assign tab_b = {1'b0, occupied_count} + {1'b0, virt_b};
  assign range_bad = (occ_i >= occupied_count) || (occ_j >= occupied_count) ||
                     (virt_a >= virtual_count) || (virt_b >= virtual_count) ||
                     ({1'b0, occ_i} >= MAX_INDEX) || ({1'b0, occ_j} >= MAX_INDEX) ||
                     (tab_a >= MAX_INDEX) || (tab_b >= MAX_INDEX);

  // Table read order: i, j, then the two virtual entries.
  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    rd_addr = occ_i[ADDR_WIDTH-1:0];
      2'd1:    rd_addr = occ_j[ADDR_WIDTH-1:0];
      2'd2:    rd_addr = tab_a[ADDR_WIDTH-1:0];
      default: rd_addr = tab_b[ADDR_WIDTH-1:0];
    endcase
  end

  // Divider setup: magnitudes, and the early overflow test. The quotient exceeds
  // the saturation limit exactly when the numerator shifted down by the quotient
  // width is not below the divisor magnitude.
  logic [ENERGY_WIDTH-1:0] nm_setup;
  logic [DEN_WIDTH-1:0]    dm_setup;
  logic [NUM_WIDTH-1:0]    num_full;
  logic [NUM_WIDTH-1:0]    num_high;
  logic                    ovf_setup;

  assign nm_setup  = adapted[ENERGY_WIDTH-1] ? ENERGY_WIDTH'(-adapted) : adapted;
  assign dm_setup  = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : den;
  assign num_full  = {nm_setup, {FRAC_BITS{1'b0}}};
  assign num_high  = num_full >> QBITS;
  assign ovf_setup = num_high >= NUM_WIDTH'(dm_setup);

  // One restoring-division step and one MSB-first shift-add step per cycle.
  logic [DEN_WIDTH:0]           trial;
  logic                         q_bit;
  logic signed [PROD_WIDTH-1:0] plain_ext;
  assign trial     = {rem, num_bits[QBITS-1]};
  assign q_bit     = trial >= {1'b0, dm};
  assign plain_ext = PROD_WIDTH'(plain);

  // Final sum with saturation.
  logic signed [TERM_WIDTH-1:0]  term;
  logic signed [SUM_WIDTH+1:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0]   sum_sat;
  logic                          term_used;
  logic                          out_free;

  assign term     = prod[PROD_WIDTH-1:FRAC_BITS];
  assign sum_wide = (SUM_WIDTH + 2)'(energy_acc) + (SUM_WIDTH + 2)'(term);
  always_comb begin
    if (!sum_wide[SUM_WIDTH+1] && (sum_wide[SUM_WIDTH:SUM_WIDTH-1] != 2'b00)) begin
      sum_sat = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else if (sum_wide[SUM_WIDTH+1] &&
                 (sum_wide[SUM_WIDTH:SUM_WIDTH-1] != 2'b11)) begin
      sum_sat = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end
  assign term_used = !range_err && !zero_den;
  assign out_free  = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept && (s_tuser == CMD_TERM)) state_next = ST_CHECK;
      end
      ST_CHECK: state_next = range_bad ? ST_SUM : ST_READ;
      ST_READ: begin
        if (rd_cnt == 3'd4) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        if (den == '0) begin
          state_next = ST_SUM;
        end else if (ovf_setup) begin
          state_next = ST_FIX;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == CNT_WIDTH'(1)) state_next = ST_FIX;
      end
      ST_FIX: state_next = ST_SUM;
      ST_SUM: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          occ_i     <= s_tdata[47:40];
          occ_j     <= s_tdata[55:48];
          virt_a    <= s_tdata[63:56];
          virt_b    <= s_tdata[71:64];
          adapted   <= s_tdata[103:72];
          plain     <= s_tdata[135:104];
          last_term <= s_tlast;
        end
      end
      ST_CHECK: begin
        range_err <= range_bad;
        zero_den  <= 1'b0;
        den       <= '0;
        rd_cnt    <= 3'd0;
      end
      ST_READ: begin
        rd_cnt <= rd_cnt + 3'd1;
        if (rd_cnt != 3'd0) begin
          if (rd_cnt >= 3'd3) begin
            den <= den - DEN_WIDTH'($signed(rd_data));
          end else begin
            den <= den + DEN_WIDTH'($signed(rd_data));
          end
        end
      end
      ST_SETUP: begin
        zero_den <= (den == '0);
        amp_neg  <= adapted[ENERGY_WIDTH-1] ^ den[DEN_WIDTH-1];
        amp_sat  <= ovf_setup;
        dm       <= dm_setup;
        rem      <= num_high[DEN_WIDTH-1:0];
        num_bits <= num_full[QBITS-1:0];
        div_cnt  <= CNT_WIDTH'(QBITS);
        quot     <= '0;
        prod     <= '0;
      end
      ST_DIV: begin
        rem      <= q_bit ? DEN_WIDTH'(trial - {1'b0, dm}) : trial[DEN_WIDTH-1:0];
        num_bits <= num_bits << 1;
        quot     <= {quot[QBITS-2:0], q_bit};
        prod     <= (prod <<< 1) + (q_bit ? plain_ext : PROD_WIDTH'(0));
        div_cnt  <= div_cnt - CNT_WIDTH'(1);
      end
      ST_FIX: begin
        if (amp_sat) begin
          // Saturated amplitude: product taken against the limit value directly.
          if (amp_neg) begin
            amp  <= ~AMP_POS_LIMIT;
            prod <= -(plain_ext <<< QBITS);
          end else begin
            amp  <= AMP_POS_LIMIT;
            prod <= (plain_ext <<< QBITS) - plain_ext;
          end
        end else if (amp_neg) begin
          amp  <= -ENERGY_WIDTH'(quot);
          prod <= -prod;
        end else begin
          amp  <= ENERGY_WIDTH'(quot);
        end
      end
      default: ;
    endcase
  end

  // Energy sum and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if ((state == ST_SUM) && out_free) begin
        m_tvalid <= 1'b1;
        if (last_term) begin
          energy_acc <= '0;
        end else if (term_used) begin
          energy_acc <= sum_sat;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SUM) && out_free) begin
      m_tdata[ENERGY_WIDTH-1:0] <= term_used ? amp : '0;
      m_tdata[M_TDATA_WIDTH-1:ENERGY_WIDTH] <= term_used ? sum_sat : energy_acc;
      m_tuser <= {range_err, zero_den};
      m_tlast <= last_term;
    end
  end

endmodule
